>>> design/rie_pkg.sv
// Package with types, codes and constants of the instruction execute block.
package rie_pkg;

	localparam int unsigned REG_COUNT_DEF = 16;
	localparam int unsigned MEM_WORDS_DEF = 4096;

	typedef enum logic [4:0] {
		CMD_ADD = 5'd0, CMD_ADDL = 5'd1, CMD_SUB = 5'd2, CMD_SUBL = 5'd3,
		CMD_MUL = 5'd4, CMD_DIV = 5'd5, CMD_AND = 5'd6, CMD_OR = 5'd7,
		CMD_XOR = 5'd8, CMD_CMP = 5'd9, CMD_MOVC = 5'd10, CMD_LOAD = 5'd11,
		CMD_STORE = 5'd12, CMD_LDR = 5'd13, CMD_STR = 5'd14, CMD_BZ = 5'd15,
		CMD_BNZ = 5'd16, CMD_NOP = 5'd17, CMD_HALT = 5'd18
	} cmd_t;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_DIV0 = 2'd1;
	localparam logic [1:0] STAT_ADDR = 2'd2;

	typedef struct packed {
		logic [4:0] command;
		logic [3:0] dest_reg;
		logic [3:0] src1_reg;
		logic [3:0] src2_reg;
		logic [3:0] src3_reg;
		logic signed [31:0] immediate;
		logic [15:0] instr_pc;
	} instr_t;

	typedef struct packed {
		logic write_enable;
		logic [3:0] write_reg;
		logic signed [31:0] write_value;
		logic zero_out;
		logic branch_taken;
		logic [15:0] branch_target;
		logic halted;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quot;
	} div_rsp_t;

endpackage

>>> design/rie_div.sv
// Iterative signed divider, one quotient bit per cycle.
module rie_div import rie_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q, done_q;
	logic [32:0] trial;
	logic [31:0] rsh;

	assign rsh = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, rsh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num[31] ? -req.num : req.num;
			den_q <= req.den[31] ? -req.den : req.den;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -quo_q : quo_q;
endmodule

>>> design/risc_instruction_execute_top.sv
// Top level of the instruction execute block with register file and data memory.
//  channel | direction | handshake      | payload
//  instr   | in        | instr_valid/instr_stall | instr_t
//  result  | out       | result_valid/result_stall | result_t
// An item passes through register read, execute, memory read and write back.
// Items are accepted only in the idle state, so a new item waits until the previous one is done.
// MUL passes through an extra state for its product register; DIV waits for the divider to report done.
// After reset a clearing pass writes zero to every data word and register, during which no item is accepted.
// A new item is taken once the previous result has moved to the output register.
module risc_instruction_execute_top import rie_pkg::*; #(
	parameter int unsigned REG_COUNT = REG_COUNT_DEF,
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic instr_valid,
	output logic instr_stall,
	input instr_t instr,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);
	localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int unsigned CLR_N = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
	localparam int unsigned CW = $clog2(CLR_N) + 1;

	typedef enum logic [7:0] {
		ST_CLR = 8'b00000001, ST_IDLE = 8'b00000010, ST_RD = 8'b00000100,
		ST_EX = 8'b00001000, ST_MUL = 8'b00010000, ST_DIV = 8'b00100000,
		ST_MEM = 8'b01000000, ST_WB = 8'b10000000
	} state_t;

	state_t state_q;
	logic [31:0] rf [REG_COUNT];
	logic [31:0] dm [MEM_WORDS];
	instr_t ins_q;
	logic [RW-1:0] rd_q;
	logic [31:0] v1_q, v2_q, v3_q, val_q, mrd_q, prod_q, addr_q;
	logic [CW-1:0] clr_q;
	logic zero_q, out_v_q, we_q, setz_q, load_q;
	logic [1:0] stat_q;
	result_t res_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [RW-1:0] i1, i2, i3;
	logic [31:0] addr_c, imm;
	logic oor;
	cmd_t cmd;

	function automatic logic [RW-1:0] reg_idx(input logic [3:0] f);
		logic [RW-1:0] r;
		r = '0;
		for (int k = 0; k < 16; k++)
			if (f == 4'(k)) r = RW'(k % REG_COUNT);
		return r;
	endfunction

	assign cmd = cmd_t'(ins_q.command);
	assign imm = ins_q.immediate;
	assign i1 = reg_idx(ins_q.src1_reg);
	assign i2 = reg_idx(ins_q.src2_reg);
	assign i3 = reg_idx(ins_q.src3_reg);

	always_comb begin
		unique case (cmd)
			CMD_LOAD: addr_c = v1_q + imm;
			CMD_STORE: addr_c = v2_q + imm;
			default: addr_c = v1_q + v2_q;
		endcase
	end
	assign oor = addr_q >= 32'(MEM_WORDS);

	assign dreq.start = (state_q == ST_EX) && (cmd == CMD_DIV) && (v2_q != '0);
	assign dreq.num = v1_q;
	assign dreq.den = v2_q;

	rie_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign instr_stall = (state_q != ST_IDLE);
	assign result_valid = out_v_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			if (clr_q < CW'(MEM_WORDS)) dm[clr_q[AW-1:0]] <= '0;
			if (clr_q < CW'(REG_COUNT)) rf[clr_q[RW-1:0]] <= '0;
		end else if (state_q == ST_MEM && !oor && (cmd == CMD_STORE || cmd == CMD_STR)) begin
			dm[addr_q[AW-1:0]] <= (cmd == CMD_STORE) ? v1_q : v3_q;
		end
		mrd_q <= dm[addr_q[AW-1:0]];
		if (state_q == ST_WB && we_q) rf[rd_q] <= load_q ? mrd_q : val_q;
		if (state_q == ST_IDLE && instr_valid) begin
			ins_q <= instr;
			rd_q <= reg_idx(instr.dest_reg);
		end
		if (state_q == ST_RD) begin
			v1_q <= rf[i1];
			v2_q <= rf[i2];
			v3_q <= rf[i3];
		end
		if (state_q == ST_EX) prod_q <= v1_q * v2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			zero_q <= 1'b0;
			out_v_q <= 1'b0;
			we_q <= 1'b0;
			setz_q <= 1'b0;
			load_q <= 1'b0;
			stat_q <= STAT_OK;
			val_q <= '0;
			addr_q <= '0;
			res_q <= '0;
		end else begin
			if (out_v_q && !result_stall) out_v_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (instr_valid) state_q <= ST_RD;
				ST_RD: state_q <= ST_EX;
				ST_EX: begin
					we_q <= 1'b1;
					setz_q <= 1'b1;
					load_q <= 1'b0;
					stat_q <= STAT_OK;
					addr_q <= addr_c;
					state_q <= ST_MEM;
					case (cmd)
						CMD_ADD: val_q <= v1_q + v2_q;
						CMD_ADDL: val_q <= v1_q + imm;
						CMD_SUB: val_q <= v1_q - v2_q;
						CMD_SUBL: val_q <= v1_q - imm;
						CMD_MUL: state_q <= ST_MUL;
						CMD_DIV: begin
							val_q <= '0;
							if (v2_q == '0) stat_q <= STAT_DIV0;
							else state_q <= ST_DIV;
						end
						CMD_AND: val_q <= v1_q & v2_q;
						CMD_OR: val_q <= v1_q | v2_q;
						CMD_XOR: val_q <= v1_q ^ v2_q;
						CMD_CMP: begin val_q <= v1_q - v2_q; we_q <= 1'b0; end
						CMD_MOVC: val_q <= imm;
						CMD_LOAD, CMD_LDR: begin
							setz_q <= 1'b0;
							load_q <= 1'b1;
						end
						default: begin
							we_q <= 1'b0;
							setz_q <= 1'b0;
							val_q <= '0;
						end
					endcase
				end
				ST_MUL: begin
					val_q <= prod_q;
					state_q <= ST_MEM;
				end
				ST_DIV: if (drsp.done) begin
					val_q <= drsp.quot;
					state_q <= ST_MEM;
				end
				ST_MEM: begin
					if ((cmd == CMD_LOAD || cmd == CMD_LDR || cmd == CMD_STORE
						|| cmd == CMD_STR) && oor) begin
						stat_q <= STAT_ADDR;
						we_q <= 1'b0;
					end
					state_q <= ST_WB;
				end
				ST_WB: if (!out_v_q || !result_stall) begin
					logic nz;
					nz = setz_q ? ((load_q ? mrd_q : val_q) == '0) : zero_q;
					zero_q <= nz;
					res_q.write_enable <= we_q;
					res_q.write_reg <= we_q ? 4'(rd_q) : 4'd0;
					res_q.write_value <= we_q ? (load_q ? mrd_q : val_q) : '0;
					res_q.zero_out <= nz;
					res_q.branch_taken <= (cmd == CMD_BZ) ? zero_q :
						(cmd == CMD_BNZ) ? !zero_q : 1'b0;
					res_q.branch_target <= (cmd == CMD_BZ || cmd == CMD_BNZ)
						? (ins_q.instr_pc + imm[15:0]) : 16'd0;
					res_q.halted <= (cmd == CMD_HALT);
					res_q.status <= stat_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
